### rtl/core/swbm_pkg.sv
// Shared types and constants for the sliding window bandwidth meter.
package swbm_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int MIN_KEEP_EVENTS = 10;

    localparam int SIZE_W   = 32;
    localparam int TIME_W   = 48;
    localparam int KEEP_W   = 16;
    localparam int US_W     = 20;
    localparam int LIMIT_W  = KEEP_W + US_W;
    localparam int RATE_W   = 58;
    localparam int BYTES_W  = 38;
    localparam int EVENTS_W = 7;

    localparam logic [US_W-1:0]    US_PER_SEC  = 20'd1000000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(US_PER_SEC);
    localparam logic [63:0]        RATE_MAX    = 64'h03FF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        BYTES_MAX   = 64'h0000_003F_FFFF_FFFF;

    typedef struct packed {
        logic [SIZE_W-1:0] data_size;
        logic [TIME_W-1:0] timestamp_us;
    } swbm_in_t;

    typedef struct packed {
        logic [RATE_W-1:0]   bytes_per_second;
        logic [BYTES_W-1:0]  window_bytes;
        logic [EVENTS_W-1:0] window_events;
        logic                overflow;
    } swbm_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_READ,
        S_CHECK,
        S_RATE
    } swbm_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_MUL,
        R_DIV
    } swbm_rate_state_t;

endpackage

### rtl/core/swbm_ram.sv
// Generic single-port-write, registered-read RAM.
module swbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/swbm_rate.sv
// Rate unit: sum * 1e6 by shift-add, then restoring division by the span.
module swbm_rate #(
    parameter int SUM_W = 38
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              sum_in,
    input  logic [swbm_pkg::TIME_W-1:0]   span_in,
    output logic                          done,
    output logic [swbm_pkg::RATE_W-1:0]   rate
);

    localparam int PROD_W = SUM_W + swbm_pkg::US_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int TW     = swbm_pkg::TIME_W;

    swbm_pkg::swbm_rate_state_t state_reg, state_next;

    logic [PROD_W-1:0]          dq_reg, dq_next;
    logic [PROD_W-1:0]          mcand_reg, mcand_next;
    logic [swbm_pkg::US_W-1:0]  mult_reg, mult_next;
    logic [TW-1:0]              rem_reg, rem_next;
    logic [TW-1:0]              span_reg, span_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [swbm_pkg::RATE_W-1:0] rate_reg, rate_next;

    logic [TW:0]                trial;
    logic                       qbit;
    logic [PROD_W-1:0]          quot;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swbm_pkg::R_IDLE:
            begin
                if (start)
                begin
                    state_next = swbm_pkg::R_MUL;
                end
            end
            swbm_pkg::R_MUL:
            begin
                if (mult_reg == swbm_pkg::US_W'(1))
                begin
                    state_next = swbm_pkg::R_DIV;
                end
            end
            swbm_pkg::R_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = swbm_pkg::R_IDLE;
                end
            end
            default:
            begin
                state_next = swbm_pkg::R_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        trial      = {rem_reg, dq_reg[PROD_W-1]};
        qbit       = (trial >= {1'b0, span_reg});
        quot       = {dq_reg[PROD_W-2:0], qbit};
        dq_next    = dq_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        rem_next   = rem_reg;
        span_next  = span_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rate_next  = rate_reg;
        unique case (state_reg)
            swbm_pkg::R_IDLE:
            begin
                if (start)
                begin
                    dq_next    = '0;
                    mcand_next = PROD_W'(sum_in);
                    mult_next  = swbm_pkg::US_PER_SEC;
                    span_next  = span_in;
                end
            end
            swbm_pkg::R_MUL:
            begin
                // add one shifted partial product per cycle
                if (mult_reg[0])
                begin
                    dq_next = dq_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PROD_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[swbm_pkg::US_W-1:1]};
                rem_next   = '0;
                cnt_next   = CNT_W'(PROD_W);
            end
            swbm_pkg::R_DIV:
            begin
                // one quotient bit per cycle
                if (qbit)
                begin
                    rem_next = TW'(trial - {1'b0, span_reg});
                end
                else
                begin
                    rem_next = TW'(trial);
                end
                dq_next  = quot;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next = 1'b1;
                    if (quot > PROD_W'(swbm_pkg::RATE_MAX))
                    begin
                        rate_next = swbm_pkg::RATE_W'(swbm_pkg::RATE_MAX);
                    end
                    else
                    begin
                        rate_next = swbm_pkg::RATE_W'(quot);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swbm_pkg::R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg    <= dq_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        rem_reg   <= rem_next;
        span_reg  <= span_next;
        cnt_reg   <= cnt_next;
        rate_reg  <= rate_next;
    end

    assign done = done_reg;
    assign rate = rate_reg;

endmodule

### rtl/core/sliding_window_bandwidth_meter_core.sv
// Sliding window bandwidth meter: top level with event ring, eviction and rate.
// Flow: the accepted word is pushed, the oldest event is read and checked, and each
// eviction repeats the read and check; when a rate is needed, the rate unit runs its
// multiply and divide before the result is handed off.
// Throughput: one word at a time; busy drops when done rises; results cannot be stalled.
// Reset: ring empty, byte sum zero, keep interval 1 s; ring memories are not cleared.
module sliding_window_bandwidth_meter_core #(
    parameter int RING_DEPTH = swbm_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  swbm_pkg::swbm_in_t            item,
    input  logic                          cfg_we,
    input  logic [swbm_pkg::KEEP_W-1:0]   cfg_wdata,
    output logic                          done,
    output swbm_pkg::swbm_out_t           result
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = swbm_pkg::SIZE_W + $clog2(RING_DEPTH);
    localparam int TW    = swbm_pkg::TIME_W;
    localparam int SW    = swbm_pkg::SIZE_W;

    // Control state
    swbm_pkg::swbm_state_t state_reg, state_next;

    logic [PTR_W-1:0]            newest_reg, newest_next;
    logic [PTR_W-1:0]            oldest_reg, oldest_next;
    logic [CNT_W-1:0]            held_reg, held_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [swbm_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic                        done_reg, done_next;

    // Word payload held for the duration of one event
    logic [SW-1:0]               size_reg, size_next;
    logic [TW-1:0]               ts_reg, ts_next;
    logic                        ovf_reg, ovf_next;
    swbm_pkg::swbm_out_t         result_reg, result_next;

    // Ring memories
    logic                        ram_we;
    logic [PTR_W-1:0]            ram_waddr;
    logic [SW-1:0]               rd_size;
    logic [TW-1:0]               rd_time;

    // Rate unit handshake
    logic                        rate_start;
    logic                        rate_done;
    logic [swbm_pkg::RATE_W-1:0] rate_val;

    logic                        full;
    logic [TW-1:0]               span;
    logic                        evict;
    logic                        need_rate;
    logic [SUM_W-1:0]            bytes_sat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        begin
            if (p == PTR_W'(RING_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + PTR_W'(1);
            end
            return r;
        end
    endfunction

    // The read port always points at the oldest held event; its data is valid in the
    // cycle after oldest_reg settles, which is why READ sits between PUSH and CHECK.
    swbm_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (size_reg),
        .raddr (oldest_reg),
        .rdata (rd_size)
    );

    swbm_ram #(
        .WIDTH (TW),
        .DEPTH (RING_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ts_reg),
        .raddr (oldest_reg),
        .rdata (rd_time)
    );

    // The rate unit latches the byte sum and the span in the CHECK cycle that starts it.
    swbm_rate #(
        .SUM_W (SUM_W)
    ) u_rate (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rate_start),
        .sum_in  (sum_reg),
        .span_in (span),
        .done    (rate_done),
        .rate    (rate_val)
    );

    // Span of the window: newest time is the word just pushed, oldest comes from RAM.
    assign full      = (held_reg == CNT_W'(RING_DEPTH));
    assign span      = ts_reg - rd_time;
    assign evict     = (held_reg > CNT_W'(swbm_pkg::MIN_KEEP_EVENTS))
                       && (span > TW'(limit_reg));
    assign need_rate = (held_reg != '0) && (span != '0) && (sum_reg != '0);
    assign ram_we    = (state_reg == swbm_pkg::S_PUSH);
    assign ram_waddr = ptr_inc(newest_reg);
    assign bytes_sat = (sum_reg > SUM_W'(swbm_pkg::BYTES_MAX))
                       ? SUM_W'(swbm_pkg::BYTES_MAX) : sum_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swbm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = swbm_pkg::S_PUSH;
                end
            end
            swbm_pkg::S_PUSH:
            begin
                state_next = swbm_pkg::S_READ;
            end
            swbm_pkg::S_READ:
            begin
                state_next = swbm_pkg::S_CHECK;
            end
            swbm_pkg::S_CHECK:
            begin
                if (evict)
                begin
                    state_next = swbm_pkg::S_READ;
                end
                else if (need_rate)
                begin
                    state_next = swbm_pkg::S_RATE;
                end
                else
                begin
                    state_next = swbm_pkg::S_IDLE;
                end
            end
            swbm_pkg::S_RATE:
            begin
                if (rate_done)
                begin
                    state_next = swbm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = swbm_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        size_next   = size_reg;
        ts_next     = ts_reg;
        ovf_next    = ovf_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        rate_start  = 1'b0;
        limit_next  = limit_reg;

        // keep interval is stored pre-scaled to microseconds
        if (cfg_we)
        begin
            limit_next = swbm_pkg::LIMIT_W'(cfg_wdata)
                         * swbm_pkg::LIMIT_W'(swbm_pkg::US_PER_SEC);
        end

        unique case (state_reg)
            swbm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    size_next = item.data_size;
                    ts_next   = item.timestamp_us;
                end
            end
            swbm_pkg::S_PUSH:
            begin
                // A full ring drops its oldest word first; the read port already holds it.
                newest_next = ptr_inc(newest_reg);
                if (full)
                begin
                    oldest_next = ptr_inc(oldest_reg);
                    sum_next    = sum_reg + SUM_W'(size_reg) - SUM_W'(rd_size);
                    ovf_next    = 1'b1;
                end
                else
                begin
                    held_next = held_reg + CNT_W'(1);
                    sum_next  = sum_reg + SUM_W'(size_reg);
                    ovf_next  = 1'b0;
                end
            end
            swbm_pkg::S_READ:
            begin
                ovf_next = ovf_reg;
            end
            swbm_pkg::S_CHECK:
            begin
                if (evict)
                begin
                    // drop the oldest word and look again
                    oldest_next = ptr_inc(oldest_reg);
                    held_next   = held_reg - CNT_W'(1);
                    sum_next    = sum_reg - SUM_W'(rd_size);
                end
                else
                begin
                    result_next.window_bytes  = swbm_pkg::BYTES_W'(bytes_sat);
                    result_next.window_events = swbm_pkg::EVENTS_W'(held_reg);
                    result_next.overflow      = ovf_reg;
                    result_next.bytes_per_second = '0;
                    if (need_rate)
                    begin
                        rate_start = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            swbm_pkg::S_RATE:
            begin
                if (rate_done)
                begin
                    result_next.bytes_per_second = rate_val;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= swbm_pkg::S_IDLE;
            newest_reg <= '0;
            oldest_reg <= PTR_W'(1);
            held_reg   <= '0;
            sum_reg    <= '0;
            limit_reg  <= swbm_pkg::LIMIT_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
            sum_reg    <= sum_next;
            limit_reg  <= limit_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        ts_reg     <= ts_next;
        ovf_reg    <= ovf_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != swbm_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
